/* src/fevd_pkg.sv */
package fevd_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 64;
    localparam int ID_W         = 16;
    localparam int VALUE_W      = 64;
    localparam int LIMIT_W      = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // Command codes
    localparam logic [2:0] CMD_CREATE   = 3'd0;
    localparam logic [2:0] CMD_LOOKUP_V = 3'd1;
    localparam logic [2:0] CMD_LOOKUP_I = 3'd2;
    localparam logic [2:0] CMD_REBIND   = 3'd3;
    localparam logic [2:0] CMD_EVICT    = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_TRIM_SCAN, S_TRIM_PASS, S_SCAN, S_EVICT_PASS, S_ID_PASS, S_RESP
    } state_t;

    typedef enum logic [1:0] { SK_ANY, SK_VALUE, SK_ID } scan_kind_t;
    typedef enum logic { PK_COMPACT, PK_REBIND } pass_kind_t;
    typedef enum logic [2:0] {
        RK_VALUE, RK_NEW, RK_FULL, RK_ID, RK_CLEAR, RK_BAD
    } resp_kind_t;

    typedef struct packed {
        logic       load_req;
        logic       scan_start;
        scan_kind_t scan_kind;
        logic       pass_start;
        pass_kind_t pass_kind;
        logic       pass_oldest;
        logic       resp_load;
        resp_kind_t resp_kind;
    } ctl_cmd_t;

    typedef struct packed {
        logic [2:0] req_cmd;
        logic       scan_done;
        logic       pass_done;
        logic       hit;
        logic       ge_lim;
        logic       over_lim;
        logic       out_busy;
    } ctl_stat_t;

endpackage

/* src/fevd_ram.sv */
module fevd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/fevd_datapath.sv */
module fevd_datapath #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fevd_pkg::ctl_cmd_t      ctl,
    output fevd_pkg::ctl_stat_t     stat,
    input  logic                    cfg_wr_en,
    input  logic [6:0]              cfg_wr_data,
    input  logic [2:0]              s_command,
    input  logic [15:0]             s_entry_id,
    input  logic [63:0]             s_key_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic [15:0]             m_result_id,
    output logic [63:0]             m_result_value
);
    import fevd_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int EW = ID_W + KEY_BITS + AW;
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    logic [2:0]          req_cmd_reg;
    logic [ID_W-1:0]     req_id_reg;
    logic [KEY_BITS-1:0] req_key_reg;
    logic [LIMIT_W-1:0]  max_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [ID_W-1:0]     next_id_reg;
    logic                scan_act_reg, pass_act_reg;
    scan_kind_t          scan_kind_reg;
    pass_kind_t          pass_kind_reg;
    logic [CW-1:0]       j_reg;
    logic                rd_vld_reg;
    logic [AW-1:0]       rd_pos_reg;
    logic                hit_reg;
    logic [AW-1:0]       fpos_reg, frank_reg, orank_reg, tpos_reg, trank_reg;
    logic [ID_W-1:0]     fid_reg;
    logic [KEY_BITS-1:0] fval_reg;
    logic                m_valid_reg;
    logic [1:0]          st_reg;
    logic [ID_W-1:0]     rid_reg;
    logic [VALUE_W-1:0]  rv_reg;

    logic [LW-1:0]       lim, max_ext, cnt_ext;
    logic                issue, scan_done, pass_done;
    logic [EW-1:0]       rd_data, wr_data;
    logic [ID_W-1:0]     e_id;
    logic [KEY_BITS-1:0] e_val;
    logic [AW-1:0]       e_rank, adj_rank;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic                append;

    // Effective entry limit
    always_comb begin
        max_ext = LW'(max_reg);
        cnt_ext = LW'(count_reg);
        if (max_reg == '0) begin
            lim = LW'(1);
        end else if (max_ext > CAP_L) begin
            lim = CAP_L;
        end else begin
            lim = max_ext;
        end
    end

    assign issue     = (scan_act_reg || pass_act_reg) && (j_reg < count_reg);
    assign scan_done = scan_act_reg && (j_reg == count_reg) && !rd_vld_reg;
    assign pass_done = pass_act_reg && (j_reg == count_reg) && !rd_vld_reg;
    assign append    = ctl.resp_load && (ctl.resp_kind == RK_NEW);

    assign {e_id, e_val, e_rank} = rd_data;
    assign adj_rank = (e_rank > trank_reg) ? e_rank - AW'(1) : e_rank;

    // Select write: append or pass rewrite
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = rd_pos_reg;
        wr_data = {e_id, e_val, adj_rank};
        if (append) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[AW-1:0];
            wr_data = {next_id_reg, req_key_reg, count_reg[AW-1:0]};
        end else if (pass_act_reg && rd_vld_reg) begin
            if (pass_kind_reg == PK_COMPACT) begin
                wr_en   = (rd_pos_reg != tpos_reg);
                wr_addr = (rd_pos_reg > tpos_reg) ? rd_pos_reg - AW'(1) : rd_pos_reg;
            end else begin
                wr_en = 1'b1;
                if (rd_pos_reg == tpos_reg) begin
                    wr_data = {e_id, req_key_reg, AW'(count_reg - CW'(1))};
                end
            end
        end
    end

    fevd_ram #(.WIDTH(EW), .DEPTH(CAPACITY), .ADDR_W(AW)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (j_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Next entry count
    always_comb begin
        count_next = count_reg;
        if (ctl.resp_load && ctl.resp_kind == RK_CLEAR) begin
            count_next = '0;
        end else if (append) begin
            count_next = count_reg + CW'(1);
        end else if (pass_done && pass_kind_reg == PK_COMPACT) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Control state: counters, scan and pass sequencing, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg      <= LIMIT_RESET;
            count_reg    <= '0;
            next_id_reg  <= ID_W'(1);
            scan_act_reg <= 1'b0;
            pass_act_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
            count_reg  <= count_next;
            rd_vld_reg <= issue;
            if (ctl.resp_load && ctl.resp_kind == RK_CLEAR) begin
                next_id_reg <= ID_W'(1);
            end else if (append) begin
                next_id_reg <= (next_id_reg == '1) ? ID_W'(1) : next_id_reg + ID_W'(1);
            end
            if (ctl.scan_start) begin
                scan_act_reg <= 1'b1;
            end else if (scan_done) begin
                scan_act_reg <= 1'b0;
            end
            if (ctl.pass_start) begin
                pass_act_reg <= 1'b1;
            end else if (pass_done) begin
                pass_act_reg <= 1'b0;
            end
            if (ctl.resp_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, scan index and match tracking
    always_ff @(posedge aclk) begin
        if (ctl.load_req) begin
            req_cmd_reg <= s_command;
            req_id_reg  <= s_entry_id;
            req_key_reg <= s_key_value[KEY_BITS-1:0];
        end
        rd_pos_reg <= j_reg[AW-1:0];
        if (ctl.scan_start || ctl.pass_start) begin
            j_reg <= '0;
        end else if (issue) begin
            j_reg <= j_reg + CW'(1);
        end
        if (ctl.scan_start) begin
            scan_kind_reg <= ctl.scan_kind;
            hit_reg       <= 1'b0;
        end else if (scan_act_reg && rd_vld_reg) begin
            if (rd_pos_reg == '0) begin
                orank_reg <= e_rank;
            end
            if ((scan_kind_reg == SK_VALUE && e_val == req_key_reg &&
                 (!hit_reg || e_rank > frank_reg)) ||
                (scan_kind_reg == SK_ID && e_id == req_id_reg && !hit_reg)) begin
                hit_reg   <= 1'b1;
                fpos_reg  <= rd_pos_reg;
                frank_reg <= e_rank;
                fid_reg   <= e_id;
                fval_reg  <= e_val;
            end
        end
        if (ctl.pass_start) begin
            pass_kind_reg <= ctl.pass_kind;
            tpos_reg      <= ctl.pass_oldest ? '0 : fpos_reg;
            trank_reg     <= ctl.pass_oldest ? orank_reg : frank_reg;
        end
    end

    // Form the result
    always_ff @(posedge aclk) begin
        if (ctl.resp_load) begin
            unique case (ctl.resp_kind)
                RK_VALUE: begin
                    st_reg  <= hit_reg ? ST_OK : ST_MISS;
                    rid_reg <= hit_reg ? fid_reg : '0;
                    rv_reg  <= VALUE_W'(req_key_reg);
                end
                RK_NEW: begin
                    st_reg  <= ST_OK;
                    rid_reg <= next_id_reg;
                    rv_reg  <= VALUE_W'(req_key_reg);
                end
                RK_FULL: begin
                    st_reg  <= ST_FULL;
                    rid_reg <= '0;
                    rv_reg  <= VALUE_W'(req_key_reg);
                end
                RK_ID: begin
                    st_reg  <= hit_reg ? ST_OK : ST_MISS;
                    rid_reg <= req_id_reg;
                    if (!hit_reg) begin
                        rv_reg <= '0;
                    end else if (req_cmd_reg == CMD_REBIND) begin
                        rv_reg <= VALUE_W'(req_key_reg);
                    end else begin
                        rv_reg <= VALUE_W'(fval_reg);
                    end
                end
                RK_CLEAR: begin
                    st_reg  <= ST_OK;
                    rid_reg <= '0;
                    rv_reg  <= '0;
                end
                default: begin
                    st_reg  <= ST_MISS;
                    rid_reg <= '0;
                    rv_reg  <= '0;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = st_reg;
    assign m_result_id    = rid_reg;
    assign m_result_value = rv_reg;

    always_comb begin
        stat.req_cmd   = req_cmd_reg;
        stat.scan_done = scan_done;
        stat.pass_done = pass_done;
        stat.hit       = hit_reg;
        stat.ge_lim    = (cnt_ext >= lim);
        stat.over_lim  = (cnt_ext > lim);
        stat.out_busy  = m_valid_reg && !m_ready;
    end

    a_one_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        !(scan_act_reg && pass_act_reg)) else $error("scan and pass overlap");
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY)) else $error("entry count above capacity");
    a_read_src: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> $past(scan_act_reg || pass_act_reg))
        else $error("read data without a walk");
    a_trim: assert property (@(posedge aclk) disable iff (!aresetn)
        (append) |-> (count_reg < CW'(CAPACITY))) else $error("append into full table");

endmodule

/* src/fevd_ctrl.sv */
module fevd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_command,
    input  fevd_pkg::ctl_stat_t stat,
    output fevd_pkg::ctl_cmd_t  ctl
);
    import fevd_pkg::*;

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence each request
    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        ctl             = '0;
        ctl.scan_kind   = SK_ANY;
        ctl.pass_kind   = PK_COMPACT;
        ctl.resp_kind   = RK_BAD;
        unique case (state_reg)
            S_IDLE: begin
                if (stat.over_lim) begin
                    ctl.scan_start = 1'b1;
                    state_next     = S_TRIM_SCAN;
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        ctl.load_req = 1'b1;
                        case (s_command)
                            CMD_CREATE, CMD_LOOKUP_V: begin
                                ctl.scan_start = 1'b1;
                                ctl.scan_kind  = SK_VALUE;
                                state_next     = S_SCAN;
                            end
                            CMD_LOOKUP_I, CMD_REBIND, CMD_EVICT: begin
                                ctl.scan_start = 1'b1;
                                ctl.scan_kind  = SK_ID;
                                state_next     = S_SCAN;
                            end
                            default: state_next = S_RESP;
                        endcase
                    end
                end
            end
            S_TRIM_SCAN: begin
                if (stat.scan_done) begin
                    ctl.pass_start  = 1'b1;
                    ctl.pass_oldest = 1'b1;
                    state_next      = S_TRIM_PASS;
                end
            end
            S_TRIM_PASS: begin
                if (stat.pass_done) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (stat.scan_done) begin
                    state_next = S_RESP;
                    if (stat.req_cmd == CMD_CREATE && !stat.hit && stat.ge_lim) begin
                        ctl.pass_start  = 1'b1;
                        ctl.pass_oldest = 1'b1;
                        state_next      = S_EVICT_PASS;
                    end else if (stat.hit && stat.req_cmd == CMD_REBIND) begin
                        ctl.pass_start = 1'b1;
                        ctl.pass_kind  = PK_REBIND;
                        state_next     = S_ID_PASS;
                    end else if (stat.hit && stat.req_cmd == CMD_EVICT) begin
                        ctl.pass_start = 1'b1;
                        state_next     = S_ID_PASS;
                    end
                end
            end
            S_EVICT_PASS, S_ID_PASS: begin
                if (stat.pass_done) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!stat.out_busy) begin
                    ctl.resp_load = 1'b1;
                    state_next    = S_IDLE;
                    case (stat.req_cmd)
                        CMD_CREATE: begin
                            if (stat.hit) begin
                                ctl.resp_kind = RK_VALUE;
                            end else if (stat.ge_lim) begin
                                ctl.resp_kind = RK_FULL;
                            end else begin
                                ctl.resp_kind = RK_NEW;
                            end
                        end
                        CMD_LOOKUP_V: ctl.resp_kind = RK_VALUE;
                        CMD_LOOKUP_I, CMD_REBIND, CMD_EVICT: ctl.resp_kind = RK_ID;
                        CMD_CLEAR: ctl.resp_kind = RK_CLEAR;
                        default: ctl.resp_kind = RK_BAD;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_resp_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.resp_load |-> !stat.out_busy) else $error("result overwritten");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_IDLE && !stat.over_lim)) else $error("ready while busy");
    a_scan_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && stat.scan_done) |=> state_reg != S_SCAN)
        else $error("scan state stuck");

endmodule

/* src/fifo_evicting_value_dictionary_core.sv */
// Two-way dictionary of up to CAPACITY entries binding KEY_BITS-wide values
// to 16-bit ids, with oldest-first replacement once the entry limit is hit.
// Requests enter on s_valid/s_ready (command, entry_id, key_value); each gives
// exactly one result on m_valid/m_ready (status, result_id, result_value).
// The entry limit is written through cfg_wr_en/cfg_wr_data; the user must do so
// only while idle, as the block itself does not enforce this. Entries sit in
// one RAM in insertion order, each with a rank in binding order. Every create,
// lookup, rebind and evict request walks the stored entries once through the
// RAM read port; a rebind or evict that finds its id, and a create that must
// drop the oldest entry, make a second walk that rewrites or compacts the RAM.
// Clear and unknown commands walk nothing. One request is in work at a time.
// The result register frees the input side: a new request is taken while the
// previous result still waits; a stalled receiver only holds the finished
// result, and the next request waits in its final step.
// Reset empties the table, sets the id counter to 1 and the limit to 64.
// A lowered limit drops the oldest entries before the next request is taken.
module fifo_evicting_value_dictionary_core #(
    parameter int CAPACITY = fevd_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = fevd_pkg::KEY_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [15:0] s_entry_id,
    input  logic [63:0] s_key_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_result_id,
    output logic [63:0] m_result_value
);
    import fevd_pkg::*;

    ctl_cmd_t  ctl;
    ctl_stat_t stat;

    // Sequence requests
    fevd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Store and search entries
    fevd_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_command      (s_command),
        .s_entry_id     (s_entry_id),
        .s_key_value    (s_key_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_id    (m_result_id),
        .m_result_value (m_result_value)
    );

endmodule

/* verif/testbench.sv */
module testbench;
    import fevd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 160;
    localparam int NUM_SLOTS      = 64;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] id;
        logic [63:0] value;
    } dict_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [15:0] s_entry_id;
    logic [63:0] s_key_value;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [15:0] m_result_id;
    logic [63:0] m_result_value;

    // Dictionary model state
    bit          mdl_valid [NUM_SLOTS];
    logic [15:0] mdl_id    [NUM_SLOTS];
    logic [63:0] mdl_value [NUM_SLOTS];
    int          insert_order[$];
    int          bind_order[$];
    logic [15:0] mdl_next_id;
    logic [6:0]  mdl_limit_reg;

    dict_result_t pending_results[$];
    logic [63:0]  key_pool[16];
    int           error_count;
    int           idle_cycles;
    int           send_idle_pct;
    int           recv_stall_pct;

    fifo_evicting_value_dictionary_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_entry_id    (s_entry_id),
        .s_key_value   (s_key_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_result_id   (m_result_id),
        .m_result_value(m_result_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int effective_limit();
        int lim;
        lim = mdl_limit_reg;
        if (lim == 0) lim = 1;
        if (lim > NUM_SLOTS) lim = NUM_SLOTS;
        return lim;
    endfunction

    function automatic void remove_from(ref int q[$], input int slot);
        foreach (q[i]) begin
            if (q[i] == slot) begin
                q.delete(i);
                return;
            end
        end
    endfunction

    function automatic void drop_entry(int slot);
        remove_from(insert_order, slot);
        remove_from(bind_order, slot);
        mdl_valid[slot] = 1'b0;
    endfunction

    function automatic void clear_dictionary();
        foreach (mdl_valid[i]) mdl_valid[i] = 1'b0;
        insert_order.delete();
        bind_order.delete();
        mdl_next_id = 16'd1;
    endfunction

    // Newest binding wins on duplicate values
    function automatic int slot_of_value(logic [63:0] v);
        for (int i = bind_order.size() - 1; i >= 0; i--)
            if (mdl_value[bind_order[i]] == v) return bind_order[i];
        return -1;
    endfunction

    // Oldest entry wins on duplicate ids
    function automatic int slot_of_id(logic [15:0] id);
        foreach (insert_order[i])
            if (mdl_id[insert_order[i]] == id) return insert_order[i];
        return -1;
    endfunction

    function automatic void apply_limit(logic [6:0] v);
        mdl_limit_reg = v;
        while (insert_order.size() > effective_limit()) drop_entry(insert_order[0]);
    endfunction

    function automatic dict_result_t dictionary_response(logic [2:0] cmd, logic [15:0] id,
                                                          logic [63:0] v);
        dict_result_t r;
        int s;
        int free_slot;
        r.status = ST_MISS;
        r.id = '0;
        r.value = '0;
        case (cmd)
            CMD_CREATE: begin
                r.value = v;
                s = slot_of_value(v);
                if (s >= 0) begin
                    r.status = ST_OK;
                    r.id = mdl_id[s];
                end else begin
                    if (insert_order.size() >= effective_limit() && insert_order.size() > 0)
                        drop_entry(insert_order[0]);
                    free_slot = -1;
                    for (int i = NUM_SLOTS - 1; i >= 0; i--)
                        if (!mdl_valid[i]) free_slot = i;
                    if (insert_order.size() >= effective_limit() || free_slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        mdl_valid[free_slot] = 1'b1;
                        mdl_id[free_slot] = mdl_next_id;
                        mdl_value[free_slot] = v;
                        insert_order.insert(insert_order.size(), free_slot);
                        bind_order.insert(bind_order.size(), free_slot);
                        r.status = ST_OK;
                        r.id = mdl_next_id;
                        mdl_next_id = mdl_next_id + 16'd1;
                        if (mdl_next_id == 16'd0) mdl_next_id = 16'd1;
                    end
                end
            end
            CMD_LOOKUP_V: begin
                r.value = v;
                s = slot_of_value(v);
                if (s >= 0) begin
                    r.status = ST_OK;
                    r.id = mdl_id[s];
                end
            end
            CMD_LOOKUP_I, CMD_REBIND, CMD_EVICT: begin
                r.id = id;
                s = slot_of_id(id);
                if (s >= 0) begin
                    r.status = ST_OK;
                    r.value = mdl_value[s];
                    if (cmd == CMD_REBIND) begin
                        remove_from(bind_order, s);
                        bind_order.insert(bind_order.size(), s);
                        mdl_value[s] = v;
                        r.value = v;
                    end else if (cmd == CMD_EVICT) begin
                        drop_entry(s);
                    end
                end
            end
            CMD_CLEAR: begin
                clear_dictionary();
                r.status = ST_OK;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Send one request; valid stays up across back-to-back requests
    task automatic send_request(logic [2:0] cmd, logic [15:0] id, logic [63:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_entry_id  <= id;
        s_key_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.insert(pending_results.size(), dictionary_response(cmd, id, v));
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Write the limit only once the block has gone quiet
    task automatic write_limit(logic [6:0] v);
        s_valid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        apply_limit(v);
    endtask

    task automatic random_request();
        int pick;
        logic [15:0] id;
        logic [63:0] v;
        logic [2:0] cmd;
        pick = $urandom_range(99);
        if (pick < 32) cmd = CMD_CREATE;
        else if (pick < 50) cmd = CMD_LOOKUP_V;
        else if (pick < 65) cmd = CMD_LOOKUP_I;
        else if (pick < 80) cmd = CMD_REBIND;
        else if (pick < 95) cmd = CMD_EVICT;
        else if (pick < 98) cmd = CMD_CLEAR;
        else cmd = 3'($urandom_range(7, 6));
        if ($urandom_range(9) == 0) v = {$urandom, $urandom};
        else v = key_pool[$urandom_range(15)];
        if ($urandom_range(9) == 0) id = 16'($urandom);
        else id = mdl_next_id - 16'($urandom_range(effective_limit() + 2));
        send_request(cmd, id, v);
    endtask

    // Every command, extremes of the fields, duplicate values, bad codes
    task automatic test_directed();
        send_request(CMD_LOOKUP_V, 16'h0000, 64'h0);
        send_request(CMD_CREATE, 16'hFFFF, 64'h0);
        send_request(CMD_CREATE, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_CREATE, 16'h0000, 64'h0);
        send_request(CMD_CREATE, 16'h0000, 64'h1234_5678_9ABC_DEF0);
        send_request(CMD_LOOKUP_V, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_LOOKUP_I, 16'd2, 64'h0);
        send_request(CMD_LOOKUP_I, 16'hFFFF, 64'h0);
        send_request(CMD_LOOKUP_I, 16'h0000, 64'h0);
        // rebind onto an existing value: newest binding must win
        send_request(CMD_REBIND, 16'd3, 64'h0);
        send_request(CMD_LOOKUP_V, 16'h0000, 64'h0);
        send_request(CMD_CREATE, 16'h0000, 64'h0);
        send_request(CMD_REBIND, 16'd1, 64'h0);
        send_request(CMD_LOOKUP_V, 16'h0000, 64'h0);
        send_request(CMD_REBIND, 16'hFFFF, 64'h5);
        send_request(CMD_EVICT, 16'd1, 64'h0);
        send_request(CMD_EVICT, 16'd1, 64'h0);
        send_request(CMD_LOOKUP_V, 16'h0000, 64'h0);
        send_request(3'd6, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(3'd7, 16'd2, 64'h0);
        send_request(CMD_CLEAR, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_LOOKUP_I, 16'd2, 64'h0);
        send_request(CMD_CREATE, 16'h0000, 64'h77);
    endtask

    // Fill, then move the limit through its extremes and refill
    task automatic test_limits();
        for (int i = 0; i < 66; i++) send_request(CMD_CREATE, 16'h0, 64'(i + 100));
        write_limit(7'd5);
        send_request(CMD_LOOKUP_V, 16'h0, 64'd160);
        send_request(CMD_LOOKUP_V, 16'h0, 64'd100);
        write_limit(7'd0);
        send_request(CMD_CREATE, 16'h0, 64'd1);
        send_request(CMD_CREATE, 16'h0, 64'd2);
        send_request(CMD_LOOKUP_V, 16'h0, 64'd1);
        write_limit(7'd127);
        for (int i = 0; i < 70; i++) send_request(CMD_CREATE, 16'h0, 64'(i));
        write_limit(7'd1);
        send_request(CMD_LOOKUP_I, mdl_next_id - 16'd1, 64'h0);
    endtask

    task automatic test_random_phase(int items, int idle_pct, int stall_pct);
        logic [6:0] lim_choices[8];
        lim_choices = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd16, 7'd64, 7'd0};
        for (int i = 0; i < items; i++) begin
            if (i % 125 == 0) begin
                write_limit(lim_choices[$urandom_range(7)]);
                send_idle_pct  = idle_pct;
                recv_stall_pct = stall_pct;
            end
            random_request();
        end
    endtask

    // Randomly stall the result side
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result with the oldest prediction
    always @(posedge aclk) begin
        dict_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", {62'b0, m_status}, 64'h0);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (m_status !== want.status)
                    report_mismatch("status", {62'b0, m_status}, {62'b0, want.status});
                if (m_result_id !== want.id)
                    report_mismatch("result_id", {48'b0, m_result_id}, {48'b0, want.id});
                if (m_result_value !== want.value)
                    report_mismatch("result_value", m_result_value, want.value);
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        error_count    = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_command   = '0;
        s_entry_id  = '0;
        s_key_value = '0;
        m_ready     = 1'b1;
        key_pool[0] = 64'h0;
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 2; i < 16; i++) key_pool[i] = {$urandom, $urandom};
        mdl_limit_reg = LIMIT_RESET;
        clear_dictionary();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        write_limit(7'd64);
        test_limits();
        test_random_phase(250, 0, 0);
        test_random_phase(250, 47, 0);
        test_random_phase(250, 0, 47);
        test_random_phase(250, 32, 32);

        s_valid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
